[hdl/ksr_pkg.sv]
`timescale 1ns / 1ps

package ksr_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned WINDOW_W = 4;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value_out;
    logic                      last_out;
  } out_word_t;

  // Operation broadcast to every cell of the sorted chain.
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_POP    = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic signed [VALUE_W-1:0] ins_val;
  } cell_ctl_t;

endpackage

[hdl/ksr_cell.sv]
`timescale 1ns / 1ps

module ksr_cell (
  input  logic                              clk,
  input  ksr_pkg::cell_ctl_t                ctl,
  input  logic                              occ,
  input  logic signed [ksr_pkg::VALUE_W-1:0] left_val,
  input  logic                              left_place,
  input  logic signed [ksr_pkg::VALUE_W-1:0] right_val,
  output logic signed [ksr_pkg::VALUE_W-1:0] val,
  output logic                              place
);
  import ksr_pkg::*;

  logic signed [VALUE_W-1:0] val_next;

  // New value lands at or left of this cell; ties stay behind older values.
  assign place = !occ || (ctl.ins_val < val);

  always_comb begin
    val_next = val;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (place) begin
          val_next = left_place ? left_val : ctl.ins_val;
        end
      end
      CMD_POP:  val_next = right_val;
      default:  val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

[hdl/k_sorted_stream_reorder_top.sv]
`timescale 1ns / 1ps
// An accepted word is held while P values are popped to bring the store under
//   window+1 (P is 1 in steady state, more after the window is lowered), then
//   inserted; a last-marked word then drains one result per cycle. in_stall is
//   high until the word is inserted and any drain is done. The sorted cell chain
//   does one pop or insert a cycle; pops wait while the output is stalled.
// Reset (rst, synchronous, active high): store empty, window = 15, no output pending.

module k_sorted_stream_reorder_top #(
  parameter int unsigned WINDOW_MAX = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ksr_pkg::in_word_t               in_word,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output ksr_pkg::out_word_t              out_word,
  // window register
  input  logic                            window_we,
  input  logic [ksr_pkg::WINDOW_W-1:0]    window_data
);
  import ksr_pkg::*;

  localparam int unsigned DEPTH = WINDOW_MAX + 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRIM,   // pop until count <= window, then insert the held word
    S_DRAIN   // empty the store after a last word
  } state_t;

  state_t                   state;
  logic [WINDOW_W-1:0]      window;
  logic [CW-1:0]            count;
  logic signed [VALUE_W-1:0] held_val;
  logic                     held_last;

  logic [CW-1:0]            cap_m1;
  logic                     out_free;
  logic                     over;
  cell_ctl_t                ctl;

  logic signed [VALUE_W-1:0] cval  [DEPTH];
  logic                      cplace[DEPTH];

  // Capacity is window+1, clamped to the number of cells.
  assign cap_m1   = (32'(window) > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(window);
  assign out_free = !out_valid || !out_stall;
  assign over     = count > cap_m1;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    ctl.ins_val = held_val;
    ctl.cmd     = CMD_HOLD;
    case (state)
      S_TRIM: begin
        if (over) begin
          if (out_free) ctl.cmd = CMD_POP;
        end else begin
          ctl.cmd = CMD_INSERT;
        end
      end
      S_DRAIN: begin
        if (out_free) ctl.cmd = CMD_POP;
      end
      default: ctl.cmd = CMD_HOLD;
    endcase
  end

  // Sorted chain: cell 0 holds the smallest value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic occ;
    assign occ = CW'(i) < count;
    if (i == 0) begin : g_first
      if (DEPTH > 1) begin : g_more
        ksr_cell u_cell (
          .clk(clk), .ctl(ctl), .occ(occ),
          .left_val(held_val), .left_place(1'b0),
          .right_val(cval[i+1]), .val(cval[i]), .place(cplace[i])
        );
      end else begin : g_only
        ksr_cell u_cell (
          .clk(clk), .ctl(ctl), .occ(occ),
          .left_val(held_val), .left_place(1'b0),
          .right_val(held_val), .val(cval[i]), .place(cplace[i])
        );
      end
    end else if (i == DEPTH - 1) begin : g_last
      ksr_cell u_cell (
        .clk(clk), .ctl(ctl), .occ(occ),
        .left_val(cval[i-1]), .left_place(cplace[i-1]),
        .right_val(held_val), .val(cval[i]), .place(cplace[i])
      );
    end else begin : g_mid
      ksr_cell u_cell (
        .clk(clk), .ctl(ctl), .occ(occ),
        .left_val(cval[i-1]), .left_place(cplace[i-1]),
        .right_val(cval[i+1]), .val(cval[i]), .place(cplace[i])
      );
    end
  end

  // Control state, store count and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      window    <= WINDOW_W'(15);
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (window_we) window <= window_data;
      // A pop loads the output register; otherwise a taken word empties it.
      if (ctl.cmd == CMD_POP) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            held_val  <= in_word.value;
            held_last <= in_word.is_last;
            state     <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (over) begin
            if (out_free) begin
              out_word.value_out <= cval[0];
              out_word.last_out  <= 1'b0;
              count              <= count - CW'(1);
            end
          end else begin
            count <= count + CW'(1);
            state <= held_last ? S_DRAIN : S_IDLE;
          end
        end
        S_DRAIN: begin
          if (out_free) begin
            out_word.value_out <= cval[0];
            out_word.last_out  <= (count == CW'(1));
            count              <= count - CW'(1);
            if (count == CW'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
